// File: hw/rtl/wcp_pkg.sv
package wcp_pkg;

   localparam int CNT_W             = 6;
   localparam int CHAR_W            = 8;
   localparam int MAX_FIELD_DEFAULT = 63;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [CNT_W-1:0]  FIELD_RESET = 6'd50;
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;

   typedef struct packed {
      logic              ovf;
      logic              has_space;
      logic              has_char;
      logic              last;
      logic [CHAR_W-1:0] char_val;
      logic [CNT_W-1:0]  pad_cnt;
      logic [CNT_W-1:0]  words_pre;
      logic [CNT_W-1:0]  words_post;
   } wcp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } wcp_qstat_type;

endpackage

// File: hw/rtl/wcp_front.sv
module wcp_front #(
   parameter int MAX_FIELD = wcp_pkg::MAX_FIELD_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [wcp_pkg::CNT_W-1:0]  field_length,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [wcp_pkg::CHAR_W-1:0] req_char_in,
   input  logic                       req_end_of_string,
   input  wcp_pkg::wcp_qstat_type     q_stat,
   output logic                       push,
   output wcp_pkg::wcp_cmd_type       push_data
);
   import wcp_pkg::*;

   logic [CNT_W-1:0] written_ff, written_in;
   logic             pending_ff, pending_in;
   logic             started_ff, started_in;
   logic             in_word_ff, in_word_in;
   logic [CNT_W-1:0] words_ff, words_in;
   logic             ovf_ff, ovf_in;

   logic [CNT_W-1:0] limit;
   logic             accept;
   logic             is_ws;
   logic             clear;
   logic             emit;
   wcp_cmd_type      cmd;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign limit     = (field_length > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : field_length;
   assign is_ws     = (req_char_in == CHAR_SPACE) ||
                      ((req_char_in >= CHAR_TAB) && (req_char_in <= CHAR_CR));

   always_comb begin
      written_in = written_ff;
      pending_in = pending_ff;
      started_in = started_ff;
      in_word_in = in_word_ff;
      words_in   = words_ff;
      ovf_in     = ovf_ff;
      clear      = 1'b0;
      emit       = 1'b0;
      cmd        = '0;
      if (ovf_ff) begin
         if (req_end_of_string) begin
            emit           = 1'b1;
            cmd.ovf        = 1'b1;
            cmd.last       = 1'b1;
            cmd.words_post = words_ff;
            clear          = 1'b1;
         end
      end else if (written_ff >= limit) begin
         ovf_in         = 1'b1;
         emit           = 1'b1;
         cmd.ovf        = 1'b1;
         cmd.last       = req_end_of_string;
         cmd.words_post = words_ff;
         clear          = req_end_of_string;
      end else begin
         if (is_ws) begin
            if (started_ff && !pending_ff) begin
               pending_in = 1'b1;
               written_in = written_ff + CNT_W'(1);
            end
            in_word_in = 1'b0;
         end else begin
            cmd.has_space = pending_ff;
            cmd.words_pre = words_ff;
            pending_in    = 1'b0;
            if (req_char_in == CHAR_DOT) begin
               in_word_in = 1'b0;
            end else if (!in_word_ff) begin
               in_word_in = 1'b1;
               words_in   = words_ff + CNT_W'(1);
            end
            cmd.has_char = 1'b1;
            cmd.char_val = req_char_in;
            written_in   = written_ff + CNT_W'(1);
            started_in   = 1'b1;
         end
         cmd.words_post = words_in;
         if (req_end_of_string) begin
            if (pending_in) begin
               written_in = written_in - CNT_W'(1);
            end
            cmd.pad_cnt = limit - written_in;
            cmd.last    = 1'b1;
            emit        = 1'b1;
            clear       = 1'b1;
         end else begin
            emit = cmd.has_char;
         end
      end
   end

   assign push      = accept && emit;
   assign push_data = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         pending_ff <= 1'b0;
         started_ff <= 1'b0;
         in_word_ff <= 1'b0;
         words_ff   <= '0;
         ovf_ff     <= 1'b0;
      end else if (accept) begin
         if (clear) begin
            written_ff <= '0;
            pending_ff <= 1'b0;
            started_ff <= 1'b0;
            in_word_ff <= 1'b0;
            words_ff   <= '0;
            ovf_ff     <= 1'b0;
         end else begin
            written_ff <= written_in;
            pending_ff <= pending_in;
            started_ff <= started_in;
            in_word_ff <= in_word_in;
            words_ff   <= words_in;
            ovf_ff     <= ovf_in;
         end
      end
   end

   a_idle_string_empty: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (written_ff == '0) && !pending_ff)
      else $error("string without text holds a count");

endmodule

// File: hw/rtl/wcp_queue.sv
module wcp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wcp_pkg::wcp_cmd_type   push_data,
   input  logic                   pop,
   output wcp_pkg::wcp_cmd_type   head,
   output wcp_pkg::wcp_qstat_type q_stat
);
   import wcp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   wcp_cmd_type      entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !push || pop)
      else $error("push into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_stat.empty |-> !pop)
      else $error("pop from an empty queue");

endmodule

// File: hw/rtl/wcp_back.sv
module wcp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  wcp_pkg::wcp_cmd_type       head,
   input  wcp_pkg::wcp_qstat_type     q_stat,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [wcp_pkg::CHAR_W-1:0] rsp_char_out,
   output logic                       rsp_is_padding,
   output logic                       rsp_overflow,
   output logic [wcp_pkg::CNT_W-1:0]  rsp_word_total,
   output logic                       rsp_last_out
);
   import wcp_pkg::*;

   typedef enum logic [2:0] {
      PH_HEAD = 3'b001,
      PH_CHAR = 3'b010,
      PH_PAD  = 3'b100
   } wcp_phase_type;

   wcp_phase_type     phase_ff, phase_in;
   logic [CNT_W-1:0]  dots_ff, dots_in;
   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              pad_ff, pad_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  words_ff, words_in;
   logic              last_ff, last_in;

   logic load;
   logic fire;
   logic final_beat;

   assign load = !valid_ff || !rsp_stall;
   assign fire = load && !q_stat.empty;

   always_comb begin
      phase_in   = phase_ff;
      dots_in    = dots_ff;
      char_in    = CHAR_DOT;
      pad_in     = 1'b0;
      ovf_in     = 1'b0;
      words_in   = head.words_post;
      last_in    = 1'b0;
      final_beat = 1'b0;
      unique case (phase_ff)
         PH_HEAD: begin
            if (head.ovf) begin
               char_in    = CHAR_NUL;
               ovf_in     = 1'b1;
               last_in    = head.last;
               final_beat = 1'b1;
            end else if (head.has_space) begin
               char_in  = CHAR_SPACE;
               words_in = head.words_pre;
               phase_in = PH_CHAR;
            end else if (head.has_char) begin
               char_in    = head.char_val;
               final_beat = (head.pad_cnt == '0);
               last_in    = head.last && final_beat;
               phase_in   = final_beat ? PH_HEAD : PH_PAD;
               dots_in    = '0;
            end else begin
               pad_in     = 1'b1;
               final_beat = (head.pad_cnt == CNT_W'(1));
               last_in    = final_beat;
               phase_in   = final_beat ? PH_HEAD : PH_PAD;
               dots_in    = CNT_W'(1);
            end
         end
         PH_CHAR: begin
            char_in    = head.char_val;
            final_beat = (head.pad_cnt == '0);
            last_in    = head.last && final_beat;
            phase_in   = final_beat ? PH_HEAD : PH_PAD;
            dots_in    = '0;
         end
         PH_PAD: begin
            pad_in     = 1'b1;
            dots_in    = dots_ff + CNT_W'(1);
            final_beat = (dots_in == head.pad_cnt);
            last_in    = final_beat;
            phase_in   = final_beat ? PH_HEAD : PH_PAD;
         end
         default: begin
            phase_in = PH_HEAD;
         end
      endcase
      valid_in = fire ? 1'b1 : (load ? 1'b0 : valid_ff);
   end

   assign pop = fire && final_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
         dots_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (fire) begin
            phase_ff <= phase_in;
            dots_ff  <= dots_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         char_ff  <= char_in;
         pad_ff   <= pad_in;
         ovf_ff   <= ovf_in;
         words_ff <= words_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_char_out   = char_ff;
   assign rsp_is_padding = pad_ff;
   assign rsp_overflow   = ovf_ff;
   assign rsp_word_total = words_ff;
   assign rsp_last_out   = last_ff;

   a_mid_cmd_has_head: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_HEAD) |-> !q_stat.empty)
      else $error("command in progress without a queued entry");

   a_char_phase_valid: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CHAR) |-> head.has_char && !head.ovf)
      else $error("character phase on a command without a character");

   a_pad_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAD) |-> (dots_ff < head.pad_cnt) && head.last)
      else $error("padding count past its target");

endmodule

// File: hw/rtl/whitespace_collapse_pad.sv
// Whitespace normalizer with dot padding. Each req beat carries one character and an
// end-of-string mark; non-whitespace passes through, a whitespace run after text becomes
// one space that is sent only ahead of the next visible character, and the end-of-string
// beat is followed by dots up to the field length, with the word count on every rsp beat.
// A front stage classifies one character per cycle, unless the four-entry queue is full,
// into a command held in that queue; a back stage sends one rsp beat per cycle from it
// while it is not empty and rsp_stall is low. A character that releases a held space goes
// out as a space beat, then its own beat; a string's last character is followed by one beat
// per padding dot. A string over the field length yields an overflow beat, plus one marked
// last at its end-of-string beat if later; excess characters are dropped. The csr channel,
// always ready, writes the field length; values above MAX_FIELD act as MAX_FIELD.
module whitespace_collapse_pad #(
   parameter int MAX_FIELD = wcp_pkg::MAX_FIELD_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [wcp_pkg::CHAR_W-1:0] req_char_in,
   input  logic                       req_end_of_string,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [wcp_pkg::CHAR_W-1:0] rsp_char_out,
   output logic                       rsp_is_padding,
   output logic                       rsp_overflow,
   output logic [wcp_pkg::CNT_W-1:0]  rsp_word_total,
   output logic                       rsp_last_out,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [wcp_pkg::CNT_W-1:0]  csr_field_length
);
   import wcp_pkg::*;

   logic [CNT_W-1:0] field_length_ff;
   logic             push;
   logic             pop;
   wcp_cmd_type      push_data;
   wcp_cmd_type      head;
   wcp_qstat_type    q_stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_length_ff <= FIELD_RESET;
      end else if (csr_valid && csr_ready) begin
         field_length_ff <= csr_field_length;
      end
   end

   wcp_front #(
      .MAX_FIELD (MAX_FIELD)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .field_length      (field_length_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_in       (req_char_in),
      .req_end_of_string (req_end_of_string),
      .q_stat            (q_stat),
      .push              (push),
      .push_data         (push_data)
   );

   wcp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   wcp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_stat         (q_stat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_char_out   (rsp_char_out),
      .rsp_is_padding (rsp_is_padding),
      .rsp_overflow   (rsp_overflow),
      .rsp_word_total (rsp_word_total),
      .rsp_last_out   (rsp_last_out)
   );

endmodule
